// File: rtl/imr_pkg.sv
`timescale 1ns / 1ps

package imr_pkg;

  localparam int unsigned MaxIntervals = 32;
  localparam int unsigned CoordWidth   = 32;
  localparam int unsigned ValueWidth   = 32;

  typedef enum logic [1:0] {
    OP_ASSIGN      = 2'd0,
    OP_ERASE       = 2'd1,
    OP_VALUE_AT    = 2'd2,
    OP_AT_OR_AFTER = 2'd3
  } op_kind_e;

  typedef enum logic [2:0] {
    EV_REMOVED = 3'd0,
    EV_ADDED   = 3'd1,
    EV_QUERY   = 3'd2,
    EV_DONE    = 3'd3,
    EV_FULL    = 3'd4
  } event_kind_e;

endpackage

// File: rtl/interval_map_range_assign.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Payload
// cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_data_i (default value)
// in      | in        | in_valid_i/in_ready_o   | kind, range_start, range_end, assign_value, point
// out     | out       | out_valid_o/out_ready_i | event_kind, out_start, out_end, out_value, found, last
//
// One operation at a time; in_ready_o is high only while no operation is in flight.
// A query walks the table entry by entry, reading and then evaluating each, until it finds its answer.
// Assign and erase copy the table into the spare bank of one table RAM entry by entry,
// then give the reported events one by one.
// Reset empties the table and clears the default value; no clearing pass is needed.
// A stalled output holds its record and the sequencer waits behind it.

module interval_map_range_assign #(
  parameter int unsigned MAX_INTERVALS = imr_pkg::MaxIntervals,
  parameter int unsigned COORD_WIDTH   = imr_pkg::CoordWidth,
  parameter int unsigned VALUE_WIDTH   = imr_pkg::ValueWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [VALUE_WIDTH-1:0] cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             kind_i,
  input  logic [COORD_WIDTH-1:0] range_start_i,
  input  logic [COORD_WIDTH-1:0] range_end_i,
  input  logic [VALUE_WIDTH-1:0] assign_value_i,
  input  logic [COORD_WIDTH-1:0] point_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             event_kind_o,
  output logic [COORD_WIDTH-1:0] out_start_o,
  output logic [COORD_WIDTH-1:0] out_end_o,
  output logic [VALUE_WIDTH-1:0] out_value_o,
  output logic                   found_o,
  output logic                   last_o
);

  localparam int unsigned IW      = $clog2(MAX_INTERVALS);
  localparam int unsigned CW      = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned WCW     = $clog2(MAX_INTERVALS + 3);
  localparam int unsigned EvDepth = MAX_INTERVALS + 3;
  localparam int unsigned EW      = $clog2(EvDepth);
  localparam int unsigned ECW     = $clog2(EvDepth + 1);
  localparam int unsigned TW      = 2 * COORD_WIDTH + VALUE_WIDTH;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] s;
    logic [COORD_WIDTH-1:0] e;
    logic [VALUE_WIDTH-1:0] v;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_EMPTY, S_Q_RD, S_Q_EVAL, S_Q_OUT, S_SCAN_RD, S_SCAN_EVAL, S_SPLIT,
    S_JDEC, S_JREM, S_JLEFT, S_NEW, S_RIGHT, S_HOLD, S_COPY_RD, S_COPY_WR,
    S_CHECK, S_EV_RD, S_EV_OUT
  } state_e;

  state_e                 state_q;
  logic                   bank_q;
  logic [CW-1:0]          count_q;
  logic [VALUE_WIDTH-1:0] default_q;
  imr_pkg::op_kind_e      op_q;
  logic [COORD_WIDTH-1:0] l_q, r_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [CW-1:0]          rd_idx_q;
  logic [WCW-1:0]         wr_cnt_q;
  logic [ECW-1:0]         ev_cnt_q, ev_rd_q;
  logic                   loop_q;
  logic                   pend_v_q, hold_v_q, split_v_q, q_found_q;
  entry_t                 pend_q, hold_q, split_q;

  logic                   out_valid_q;
  imr_pkg::event_kind_e   ev_kind_q;
  logic [COORD_WIDTH-1:0] os_q, oe_q;
  logic [VALUE_WIDTH-1:0] ov_q;
  logic                   found_q, last_q;

  logic           tbl_re, tbl_we_req, tbl_we;
  logic [IW:0]    tbl_raddr, tbl_waddr;
  entry_t         tbl_wdata;
  logic [TW-1:0]  tbl_rdata;
  entry_t         x;
  logic           ev_re, ev_we_req, ev_we;
  logic [TW:0]    ev_wdata, ev_rdata;
  entry_t         ev_entry;

  logic out_free, in_fire, rd_more, is_assign;
  logic s_gt_r, s_eq_r, e_le_r, v_eq, x_before;
  logic j_ovl, j_merge, j_split, j_keep, full;

  assign x         = tbl_rdata;
  assign ev_entry  = ev_rdata[TW-1:0];
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_fire   = in_valid_i && in_ready_o;
  assign rd_more   = rd_idx_q < count_q;
  assign is_assign = (op_q == imr_pkg::OP_ASSIGN);

  assign s_gt_r   = x.s > r_q;
  assign s_eq_r   = x.s == r_q;
  assign e_le_r   = x.e <= r_q;
  assign v_eq     = x.v == val_q;
  assign x_before = x.s < l_q;

  assign j_ovl   = l_q < pend_q.e;
  assign j_merge = pend_v_q && is_assign && (pend_q.v == val_q) && ((pend_q.e == l_q) || j_ovl);
  assign j_split = pend_v_q && j_ovl && !(is_assign && (pend_q.v == val_q));
  assign j_keep  = pend_v_q && !j_merge && !j_split;
  assign full    = (wr_cnt_q > WCW'(MAX_INTERVALS)) || (ev_cnt_q > ECW'(MAX_INTERVALS + 3));

  assign tbl_raddr = {bank_q, rd_idx_q[IW-1:0]};
  assign tbl_waddr = {~bank_q, wr_cnt_q[IW-1:0]};
  assign tbl_we    = tbl_we_req && (wr_cnt_q < WCW'(MAX_INTERVALS));
  assign ev_we     = ev_we_req && (ev_cnt_q < ECW'(EvDepth));
  assign ev_re     = (state_q == S_EV_RD) && (ev_rd_q < ev_cnt_q);

  always_comb begin
    tbl_re     = ((state_q == S_Q_RD) || (state_q == S_SCAN_RD) || (state_q == S_COPY_RD))
                 && rd_more;
    tbl_we_req = 1'b0;
    tbl_wdata  = pend_q;
    ev_we_req  = 1'b0;
    ev_wdata   = {1'b0, x};
    unique case (state_q)
      S_SCAN_EVAL: begin
        if (!loop_q) begin
          tbl_we_req = x_before && pend_v_q;
        end else begin
          ev_we_req = !s_gt_r && (!s_eq_r || (is_assign && v_eq));
        end
      end
      S_SPLIT: begin
        ev_we_req = 1'b1;
        ev_wdata  = {1'b1, split_q};
      end
      S_JDEC: begin
        tbl_we_req = j_keep;
        if (j_merge) begin
          ev_we_req = 1'b1;
          ev_wdata  = {1'b0, pend_q};
        end else if (j_split && (r_q < pend_q.e)) begin
          ev_we_req = 1'b1;
          ev_wdata  = {1'b1, r_q, pend_q.e, pend_q.v};
        end
      end
      S_JREM: begin
        ev_we_req = 1'b1;
        ev_wdata  = {1'b0, pend_q};
      end
      S_JLEFT: begin
        tbl_we_req = 1'b1;
        tbl_wdata  = '{s: pend_q.s, e: l_q, v: pend_q.v};
        ev_we_req  = 1'b1;
        ev_wdata   = {1'b1, pend_q.s, l_q, pend_q.v};
      end
      S_NEW: begin
        tbl_we_req = is_assign;
        tbl_wdata  = '{s: l_q, e: r_q, v: val_q};
        ev_we_req  = is_assign;
        ev_wdata   = {1'b1, l_q, r_q, val_q};
      end
      S_RIGHT: begin
        tbl_we_req = split_v_q;
        tbl_wdata  = split_q;
      end
      S_HOLD: begin
        tbl_we_req = hold_v_q;
        tbl_wdata  = hold_q;
      end
      S_COPY_WR: begin
        tbl_we_req = 1'b1;
        tbl_wdata  = x;
      end
      default: begin
      end
    endcase
  end

  imr_ram #(
    .Width(TW),
    .Depth(2 ** (IW + 1))
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .re_i   (tbl_re),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  imr_ram #(
    .Width(TW + 1),
    .Depth(EvDepth)
  ) u_events (
    .clk_i  (clk_i),
    .we_i   (ev_we),
    .waddr_i(ev_cnt_q[EW-1:0]),
    .wdata_i(ev_wdata),
    .re_i   (ev_re),
    .raddr_i(ev_rd_q[EW-1:0]),
    .rdata_o(ev_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      bank_q      <= 1'b0;
      count_q     <= '0;
      default_q   <= '0;
      op_q        <= imr_pkg::OP_ASSIGN;
      rd_idx_q    <= '0;
      wr_cnt_q    <= '0;
      ev_cnt_q    <= '0;
      ev_rd_q     <= '0;
      loop_q      <= 1'b0;
      pend_v_q    <= 1'b0;
      hold_v_q    <= 1'b0;
      split_v_q   <= 1'b0;
      q_found_q   <= 1'b0;
      out_valid_q <= 1'b0;
      ev_kind_q   <= imr_pkg::EV_DONE;
      found_q     <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        default_q <= cfg_data_i;
      end
      if (ev_we_req) begin
        ev_cnt_q <= ev_cnt_q + 1'b1;
      end
      if (tbl_we_req) begin
        wr_cnt_q <= wr_cnt_q + 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            op_q      <= imr_pkg::op_kind_e'(kind_i);
            l_q       <= kind_i[1] ? point_i : range_start_i;
            r_q       <= range_end_i;
            val_q     <= assign_value_i;
            rd_idx_q  <= '0;
            wr_cnt_q  <= '0;
            ev_cnt_q  <= '0;
            loop_q    <= 1'b0;
            pend_v_q  <= 1'b0;
            hold_v_q  <= 1'b0;
            split_v_q <= 1'b0;
            q_found_q <= 1'b0;
            if (kind_i[1]) begin
              state_q <= S_Q_RD;
            end else if (range_start_i >= range_end_i) begin
              state_q <= S_EMPTY;
            end else begin
              state_q <= S_SCAN_RD;
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            ev_kind_q   <= imr_pkg::EV_DONE;
            os_q        <= '0;
            oe_q        <= '0;
            ov_q        <= '0;
            found_q     <= 1'b0;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_Q_RD: begin
          state_q <= rd_more ? S_Q_EVAL : S_Q_OUT;
        end
        S_Q_EVAL: begin
          if (x.e > l_q) begin
            hold_q    <= x;
            q_found_q <= (x.s <= l_q) || (op_q == imr_pkg::OP_AT_OR_AFTER);
            state_q   <= S_Q_OUT;
          end else begin
            rd_idx_q <= rd_idx_q + 1'b1;
            state_q  <= S_Q_RD;
          end
        end
        S_Q_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            ev_kind_q   <= imr_pkg::EV_QUERY;
            os_q        <= q_found_q ? hold_q.s : '0;
            oe_q        <= q_found_q ? hold_q.e : '0;
            ov_q        <= q_found_q ? hold_q.v : default_q;
            found_q     <= q_found_q;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_SCAN_RD: begin
          state_q <= rd_more ? S_SCAN_EVAL : S_JDEC;
        end
        S_SCAN_EVAL: begin
          state_q <= S_SCAN_RD;
          if (!loop_q) begin
            if (x_before) begin
              pend_q   <= x;
              pend_v_q <= 1'b1;
              rd_idx_q <= rd_idx_q + 1'b1;
            end else begin
              loop_q <= 1'b1;
            end
          end else if (s_gt_r) begin
            hold_q   <= x;
            hold_v_q <= 1'b1;
            rd_idx_q <= rd_idx_q + 1'b1;
            state_q  <= S_JDEC;
          end else if (s_eq_r) begin
            if (is_assign && v_eq) begin
              r_q      <= x.e;
              rd_idx_q <= rd_idx_q + 1'b1;
            end else begin
              hold_q   <= x;
              hold_v_q <= 1'b1;
              rd_idx_q <= rd_idx_q + 1'b1;
            end
            state_q <= S_JDEC;
          end else if (e_le_r) begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end else if (is_assign && v_eq) begin
            r_q      <= x.e;
            rd_idx_q <= rd_idx_q + 1'b1;
          end else begin
            split_q   <= '{s: r_q, e: x.e, v: x.v};
            split_v_q <= 1'b1;
            rd_idx_q  <= rd_idx_q + 1'b1;
            state_q   <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          state_q <= S_JDEC;
        end
        S_JDEC: begin
          state_q <= S_NEW;
          if (j_merge) begin
            l_q <= pend_q.s;
            if (j_ovl && (pend_q.e > r_q)) begin
              r_q <= pend_q.e;
            end
          end else if (j_split) begin
            if (r_q < pend_q.e) begin
              split_q   <= '{s: r_q, e: pend_q.e, v: pend_q.v};
              split_v_q <= 1'b1;
            end
            state_q <= S_JREM;
          end
        end
        S_JREM: begin
          state_q <= S_JLEFT;
        end
        S_JLEFT: begin
          state_q <= S_NEW;
        end
        S_NEW: begin
          state_q <= S_RIGHT;
        end
        S_RIGHT: begin
          state_q <= S_HOLD;
        end
        S_HOLD: begin
          state_q <= S_COPY_RD;
        end
        S_COPY_RD: begin
          state_q <= rd_more ? S_COPY_WR : S_CHECK;
        end
        S_COPY_WR: begin
          rd_idx_q <= rd_idx_q + 1'b1;
          state_q  <= S_COPY_RD;
        end
        S_CHECK: begin
          if (full) begin
            if (out_free) begin
              out_valid_q <= 1'b1;
              ev_kind_q   <= imr_pkg::EV_FULL;
              os_q        <= '0;
              oe_q        <= '0;
              ov_q        <= '0;
              found_q     <= 1'b0;
              last_q      <= 1'b1;
              state_q     <= S_IDLE;
            end
          end else begin
            bank_q  <= ~bank_q;
            count_q <= wr_cnt_q[CW-1:0];
            ev_rd_q <= '0;
            state_q <= S_EV_RD;
          end
        end
        S_EV_RD: begin
          if (ev_rd_q < ev_cnt_q) begin
            state_q <= S_EV_OUT;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            ev_kind_q   <= imr_pkg::EV_DONE;
            os_q        <= '0;
            oe_q        <= '0;
            ov_q        <= '0;
            found_q     <= 1'b0;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_EV_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            ev_kind_q   <= ev_rdata[TW] ? imr_pkg::EV_ADDED : imr_pkg::EV_REMOVED;
            os_q        <= ev_entry.s;
            oe_q        <= ev_entry.e;
            ov_q        <= ev_entry.v;
            found_q     <= 1'b0;
            last_q      <= 1'b0;
            ev_rd_q     <= ev_rd_q + 1'b1;
            state_q     <= S_EV_RD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = ev_kind_q;
  assign out_start_o  = os_q;
  assign out_end_o    = oe_q;
  assign out_value_o  = ov_q;
  assign found_o      = found_q;
  assign last_o       = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_INTERVALS))
    else $error("table count exceeds capacity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("ready while an operation is in flight");

  a_idle_no_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !tbl_we_req && !ev_we_req)
    else $error("table or event write while idle");

  a_event_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EV_RD |-> ev_cnt_q <= ECW'(MAX_INTERVALS + 3) && ev_rd_q <= ev_cnt_q)
    else $error("event replay out of range");

endmodule

// File: rtl/imr_ram.sv
`timescale 1ns / 1ps

module imr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: tb/interval_map_range_assign_checker.sv
`timescale 1ns / 1ps

module interval_map_range_assign_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [imr_pkg::ValueWidth-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [1:0]                     kind_i,
  input  logic [imr_pkg::CoordWidth-1:0] range_start_i,
  input  logic [imr_pkg::CoordWidth-1:0] range_end_i,
  input  logic [imr_pkg::ValueWidth-1:0] assign_value_i,
  input  logic [imr_pkg::CoordWidth-1:0] point_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [2:0]                     event_kind_i,
  input  logic [imr_pkg::CoordWidth-1:0] out_start_i,
  input  logic [imr_pkg::CoordWidth-1:0] out_end_i,
  input  logic [imr_pkg::ValueWidth-1:0] out_value_i,
  input  logic                           found_i,
  input  logic                           last_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  typedef struct {
    logic [imr_pkg::CoordWidth-1:0] lo;
    logic [imr_pkg::CoordWidth-1:0] hi;
    logic [imr_pkg::ValueWidth-1:0] val;
  } span_t;

  typedef struct {
    imr_pkg::event_kind_e           kind;
    logic [imr_pkg::CoordWidth-1:0] s;
    logic [imr_pkg::CoordWidth-1:0] e;
    logic [imr_pkg::ValueWidth-1:0] v;
    logic                           found;
    logic                           last;
  } record_t;

  span_t   spans[$];
  span_t   scratch[$];
  record_t edits[$];
  record_t awaited[$];
  logic [imr_pkg::ValueWidth-1:0] dflt;
  bit spill;

  function automatic void note(imr_pkg::event_kind_e k, span_t sp);
    if (edits.size() >= 2 * imr_pkg::MaxIntervals + 16) spill = 1;
    else edits.push_back('{k, sp.lo, sp.hi, sp.val, 1'b0, 1'b0});
  endfunction

  function automatic void cut(int i);
    if (i >= scratch.size()) return;
    note(imr_pkg::EV_REMOVED, scratch[i]);
    scratch.delete(i);
  endfunction

  function automatic void place(int i, logic [imr_pkg::CoordWidth-1:0] lo,
                                logic [imr_pkg::CoordWidth-1:0] hi,
                                logic [imr_pkg::ValueWidth-1:0] val);
    span_t sp;
    if (scratch.size() >= imr_pkg::MaxIntervals + 4 || i > scratch.size()) begin
      spill = 1;
      return;
    end
    sp = '{lo, hi, val};
    scratch.insert(i, sp);
    note(imr_pkg::EV_ADDED, sp);
  endfunction

  function automatic int first_from(logic [imr_pkg::CoordWidth-1:0] lo);
    int i;
    i = 0;
    while (i < scratch.size() && scratch[i].lo < lo) i++;
    return i;
  endfunction

  function automatic void paint(logic [imr_pkg::CoordWidth-1:0] l,
                                logic [imr_pkg::CoordWidth-1:0] r,
                                logic [imr_pkg::ValueWidth-1:0] val);
    int i;
    int j;
    span_t t;
    i = first_from(l);
    while (i < scratch.size() && scratch[i].lo <= r) begin
      if (scratch[i].lo == r) begin
        if (scratch[i].val == val) begin
          r = scratch[i].hi;
          cut(i);
        end
        break;
      end
      if (scratch[i].hi <= r) begin
        cut(i);
      end else if (scratch[i].val == val) begin
        r = scratch[i].hi;
        cut(i);
      end else begin
        t = scratch[i];
        cut(i);
        place(i, r, t.hi, t.val);
      end
      if (spill) return;
    end
    if (i > 0 && i <= scratch.size()) begin
      j = i - 1;
      t = scratch[j];
      if (t.hi == l) begin
        if (t.val == val) begin
          l = t.lo;
          cut(j);
        end
      end else if (l < t.hi) begin
        if (t.val == val) begin
          if (t.lo < l) l = t.lo;
          if (t.hi > r) r = t.hi;
          cut(j);
        end else begin
          if (r < t.hi) place(j + 1, r, t.hi, t.val);
          cut(j);
          place(j, t.lo, l, t.val);
        end
      end
    end
    if (spill) return;
    place(first_from(l), l, r, val);
  endfunction

  function automatic void clear(logic [imr_pkg::CoordWidth-1:0] l,
                                logic [imr_pkg::CoordWidth-1:0] r);
    int i;
    int j;
    span_t t;
    i = first_from(l);
    while (i < scratch.size() && scratch[i].lo <= r) begin
      if (scratch[i].lo == r) break;
      if (scratch[i].hi <= r) begin
        cut(i);
      end else begin
        t = scratch[i];
        cut(i);
        place(i, r, t.hi, t.val);
      end
      if (spill) return;
    end
    if (i > 0 && i <= scratch.size()) begin
      j = i - 1;
      t = scratch[j];
      if (l < t.hi) begin
        if (r < t.hi) place(j + 1, r, t.hi, t.val);
        cut(j);
        place(j, t.lo, l, t.val);
      end
    end
  endfunction

  function automatic void predict(logic [1:0] k, logic [imr_pkg::CoordWidth-1:0] l,
                                  logic [imr_pkg::CoordWidth-1:0] r,
                                  logic [imr_pkg::ValueWidth-1:0] val,
                                  logic [imr_pkg::CoordWidth-1:0] p);
    if (k == imr_pkg::OP_VALUE_AT || k == imr_pkg::OP_AT_OR_AFTER) begin
      foreach (spans[i]) begin
        if (spans[i].lo <= p && p < spans[i].hi) begin
          awaited.push_back('{imr_pkg::EV_QUERY, spans[i].lo, spans[i].hi, spans[i].val,
                              1'b1, 1'b1});
          return;
        end
      end
      if (k == imr_pkg::OP_AT_OR_AFTER) begin
        foreach (spans[i]) begin
          if (spans[i].lo > p) begin
            awaited.push_back('{imr_pkg::EV_QUERY, spans[i].lo, spans[i].hi, spans[i].val,
                                1'b1, 1'b1});
            return;
          end
        end
      end
      awaited.push_back('{imr_pkg::EV_QUERY, '0, '0, dflt, 1'b0, 1'b1});
      return;
    end
    if (l >= r) begin
      awaited.push_back('{imr_pkg::EV_DONE, '0, '0, '0, 1'b0, 1'b1});
      return;
    end
    scratch = spans;
    edits.delete();
    spill = 0;
    if (k == imr_pkg::OP_ASSIGN) paint(l, r, val);
    else clear(l, r);
    if (spill || scratch.size() > imr_pkg::MaxIntervals ||
        edits.size() + 1 > imr_pkg::MaxIntervals + 4) begin
      awaited.push_back('{imr_pkg::EV_FULL, '0, '0, '0, 1'b0, 1'b1});
      return;
    end
    spans = scratch;
    foreach (edits[i]) awaited.push_back(edits[i]);
    awaited.push_back('{imr_pkg::EV_DONE, '0, '0, '0, 1'b0, 1'b1});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    record_t x;
    if (!rst_ni) begin
      spans.delete();
      awaited.delete();
      dflt = '0;
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) dflt = cfg_data_i;
      if (in_valid_i && in_ready_i)
        predict(kind_i, range_start_i, range_end_i, assign_value_i, point_i);
      if (out_valid_i && out_ready_i) begin
        if (awaited.size() == 0) begin
          $error("unexpected result: event_kind %0d", event_kind_i);
          fail_count_o++;
        end else begin
          x = awaited.pop_front();
          if (event_kind_i !== x.kind) begin
            $error("event_kind expected %0d got %0d", x.kind, event_kind_i);
            fail_count_o++;
          end
          if (out_start_i !== x.s) begin
            $error("out_start expected %0h got %0h", x.s, out_start_i);
            fail_count_o++;
          end
          if (out_end_i !== x.e) begin
            $error("out_end expected %0h got %0h", x.e, out_end_i);
            fail_count_o++;
          end
          if (out_value_i !== x.v) begin
            $error("out_value expected %0h got %0h", x.v, out_value_i);
            fail_count_o++;
          end
          if (found_i !== x.found) begin
            $error("found expected %0b got %0b", x.found, found_i);
            fail_count_o++;
          end
          if (last_i !== x.last) begin
            $error("last expected %0b got %0b", x.last, last_i);
            fail_count_o++;
          end
        end
      end
      pending_o = awaited.size();
    end
  end

endmodule

// File: tb/interval_map_range_assign_test.sv
`timescale 1ns / 1ps

module interval_map_range_assign_test;

  localparam int IdleLimit = 5000;

  logic                           clk_i = 0;
  logic                           rst_ni = 0;
  logic                           cfg_valid_i = 0;
  logic                           cfg_ready_o;
  logic [imr_pkg::ValueWidth-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 0;
  logic                           in_ready_o;
  logic [1:0]                     kind_i = imr_pkg::OP_ASSIGN;
  logic [imr_pkg::CoordWidth-1:0] range_start_i = '0;
  logic [imr_pkg::CoordWidth-1:0] range_end_i = '0;
  logic [imr_pkg::ValueWidth-1:0] assign_value_i = '0;
  logic [imr_pkg::CoordWidth-1:0] point_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 0;
  logic [2:0]                     event_kind_o;
  logic [imr_pkg::CoordWidth-1:0] out_start_o;
  logic [imr_pkg::CoordWidth-1:0] out_end_o;
  logic [imr_pkg::ValueWidth-1:0] out_value_o;
  logic                           found_o;
  logic                           last_o;
  int                             fail_count;
  int                             pending;
  int                             burst_left = 0;
  int                             idle_cycles = 0;

  interval_map_range_assign uut (.*);

  interval_map_range_assign_checker chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .range_start_i, .range_end_i,
    .assign_value_i, .point_i, .out_valid_i(out_valid_o), .out_ready_i,
    .event_kind_i(event_kind_o), .out_start_i(out_start_o), .out_end_i(out_end_o),
    .out_value_i(out_value_o), .found_i(found_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int seg;
    int mode;
    seg = 0;
    @(posedge rst_ni);
    forever begin
      seg++;
      if (seg == 6) begin
        out_ready_i <= 0;
        repeat (600) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 2);
        repeat ($urandom_range(5, 60)) begin
          out_ready_i <= (mode == 0) ? 1'b1 :
                         (mode == 1) ? 1'($urandom_range(0, 1)) :
                         1'($urandom_range(0, 3) == 0);
          @(posedge clk_i);
        end
      end
    end
  end

  task automatic send(imr_pkg::op_kind_e op, logic [imr_pkg::CoordWidth-1:0] l,
                      logic [imr_pkg::CoordWidth-1:0] r, logic [imr_pkg::ValueWidth-1:0] v,
                      logic [imr_pkg::CoordWidth-1:0] p);
    if (burst_left == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    kind_i <= op;
    range_start_i <= l;
    range_end_i <= r;
    assign_value_i <= v;
    point_i <= p;
    in_valid_i <= 1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_default(logic [imr_pkg::ValueWidth-1:0] v);
    cfg_data_i <= v;
    cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
  endtask

  function automatic logic [imr_pkg::CoordWidth-1:0] rand_coord();
    case ($urandom_range(0, 19))
      0: return $urandom;
      1: return '1;
      2: return '0;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic logic [imr_pkg::ValueWidth-1:0] rand_value();
    return ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
  endfunction

  task automatic random_ops(int n);
    logic [imr_pkg::CoordWidth-1:0] l;
    logic [imr_pkg::CoordWidth-1:0] r;
    int pick;
    repeat (n) begin
      l = rand_coord();
      r = ($urandom_range(0, 9) == 0) ? rand_coord() : l + $urandom_range(0, 40);
      pick = $urandom_range(0, 9);
      if (pick < 4) send(imr_pkg::OP_ASSIGN, l, r, rand_value(), rand_coord());
      else if (pick < 6) send(imr_pkg::OP_ERASE, l, r, rand_value(), rand_coord());
      else if (pick < 8) send(imr_pkg::OP_VALUE_AT, l, r, rand_value(), rand_coord());
      else send(imr_pkg::OP_AT_OR_AFTER, l, r, rand_value(), rand_coord());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    set_default('1);
    send(imr_pkg::OP_VALUE_AT, 0, 0, 0, 7);
    send(imr_pkg::OP_AT_OR_AFTER, 0, 0, 0, 0);
    send(imr_pkg::OP_ASSIGN, 5, 5, 1, 0);
    send(imr_pkg::OP_ASSIGN, 9, 3, 1, 0);
    send(imr_pkg::OP_ERASE, 9, 3, 0, 0);
    send(imr_pkg::OP_ASSIGN, 10, 20, 1, 0);
    send(imr_pkg::OP_ASSIGN, 20, 30, 1, 0);
    send(imr_pkg::OP_ASSIGN, 15, 25, 2, 0);
    send(imr_pkg::OP_ERASE, 12, 27, 0, 0);
    send(imr_pkg::OP_VALUE_AT, 0, 0, 0, 11);
    send(imr_pkg::OP_AT_OR_AFTER, 0, 0, 0, 50);
    send(imr_pkg::OP_AT_OR_AFTER, 0, 0, 0, 0);
    for (int k = 0; k < 34; k++) begin
      send(imr_pkg::OP_ASSIGN, 1000 + 3 * k, 1001 + 3 * k, k, 0);
    end
    send(imr_pkg::OP_ASSIGN, 0, '1, '1, 0);
    send(imr_pkg::OP_ERASE, 0, '1, 0, 0);
    send(imr_pkg::OP_ERASE, 1000, 1060, 0, 0);
    send(imr_pkg::OP_ASSIGN, 32'hFFFF_FFF0, '1, '1, 0);
    send(imr_pkg::OP_VALUE_AT, 0, 0, 0, 32'hFFFF_FFFE);
    send(imr_pkg::OP_AT_OR_AFTER, 0, 0, 0, '1);
    drain();
    set_default($urandom);
    random_ops(89);
    drain();
    set_default('0);
    random_ops(89);
    drain();
    set_default($urandom);
    random_ops(90);
    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
